// ----- rtl/hue_colorize_matrix_defines.svh -----
// Assertion macros for the hue colorize matrix block.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef HUE_COLORIZE_MATRIX_DEFINES_SVH
`define HUE_COLORIZE_MATRIX_DEFINES_SVH

// Checked on every edge, reset included.
`define HCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

// Checked only while out of reset.
`define HCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

// ----- rtl/hcm_pkg.sv -----
// Shared types and constants for the hue colorize matrix block.
// No dependencies; used by every module of the block.
package hcm_pkg;

  localparam int unsigned COLOR_BITS = 12;
  localparam int unsigned HUE_BITS   = 16;

  localparam int unsigned PROD_W  = 2 * COLOR_BITS;
  localparam int unsigned SUM_W   = 2 * COLOR_BITS + 2;
  localparam int unsigned HFC_W   = HUE_BITS + COLOR_BITS;

  localparam logic [COLOR_BITS-1:0] FULL = {COLOR_BITS{1'b1}};
  localparam logic [COLOR_BITS-1:0] HALF = FULL >> 1;

  // one tenth of a turn, rounded
  localparam logic [HUE_BITS-1:0] SPREAD =
    HUE_BITS'(((64'd1 << HUE_BITS) + 64'd5) / 64'd10);
  localparam logic [HFC_W-1:0] HUE_HALF = HFC_W'(64'd1 << (HUE_BITS - 1));

  // sums at or above FULL * 2^COLOR_BITS divide to more than FULL
  localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'({FULL, {COLOR_BITS{1'b0}}});

  // index 0 red, 1 green, 2 blue
  typedef logic [2:0][COLOR_BITS-1:0] rgb_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red_in;
    logic [COLOR_BITS-1:0] green_in;
    logic [COLOR_BITS-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red_out;
    logic [COLOR_BITS-1:0] green_out;
    logic [COLOR_BITS-1:0] blue_out;
  } out_item_t;

  // per-stage load enables of the lane pipeline
  typedef struct packed {
    logic prod;
    logic sum;
    logic res;
  } stage_en_t;

endpackage

// ----- rtl/hue_colorize_matrix.sv -----
// Hue colorize matrix top level: hue register, mixing matrix, three channel lanes.
// Stages: input, product, sum, result; throughput 1 item per cycle unless stalled.
// The matrix columns are registered from hue_q, in the cycle after a hue write.
// A stalled output lets earlier stages keep filling bubbles before input ready drops.
// Reset clears all stage valid bits and sets hue to 0; col_q has no reset.
// Depends on hcm_pkg, hcm_hue2rgb, hcm_lane and hue_colorize_matrix_defines.svh.
`include "hue_colorize_matrix_defines.svh"

module hue_colorize_matrix (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [hcm_pkg::HUE_BITS-1:0] cfg_hue_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  hcm_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output hcm_pkg::out_item_t          out_data_o
);
  import hcm_pkg::*;

  logic [HUE_BITS-1:0] hue_q;
  logic [HUE_BITS-1:0] hue_lo, hue_hi;
  rgb_t [2:0]          col_d, col_q;
  rgb_t                x_q;
  rgb_t [2:0]          coef;
  logic [2:0][COLOR_BITS-1:0] res;

  logic      v1_q, v2_q, v3_q, ov_q;
  logic      en_in;
  stage_en_t en;

  // columns at hue - spread, hue, hue + spread (wraps in HUE_BITS)
  assign hue_lo = hue_q - SPREAD;
  assign hue_hi = hue_q + SPREAD;

  hcm_hue2rgb u_col_lo (.hue_i(hue_lo), .rgb_o(col_d[0]));
  hcm_hue2rgb u_col_mid (.hue_i(hue_q), .rgb_o(col_d[1]));
  hcm_hue2rgb u_col_hi (.hue_i(hue_hi), .rgb_o(col_d[2]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q <= '0;
    end else if (cfg_we_i) begin
      hue_q <= cfg_hue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
  end

  // stage enables: a stage moves when its successor is empty or moving
  assign en.res   = !ov_q || out_ready_i;
  assign en.sum   = !v3_q || en.res;
  assign en.prod  = !v2_q || en.sum;
  assign en_in    = !v1_q || en.prod;
  assign in_ready_o = en_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en_in) begin
        v1_q <= in_valid_i;
      end
      if (en.prod) begin
        v2_q <= v1_q;
      end
      if (en.sum) begin
        v3_q <= v2_q;
      end
      if (en.res) begin
        ov_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_in) begin
      x_q <= {in_data_i.blue_in, in_data_i.green_in, in_data_i.red_in};
    end
  end

  // lane ch takes matrix row ch: one entry from each column
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 3; k++) begin
        coef[ch][k] = col_q[k][ch];
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    hcm_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .x_i    (x_q),
      .coef_i (coef[ch]),
      .res_o  (res[ch])
    );
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = '{red_out: res[0], green_out: res[1], blue_out: res[2]};

  `HCM_ASSERT_ALWAYS(a_ready_full, !in_ready_o |-> (v1_q && v2_q && v3_q && ov_q), "input blocked with a free stage")
  `HCM_ASSERT(a_no_drop, (v1_q && !en.prod) |=> v1_q, "held item lost in input stage")
  `HCM_ASSERT(a_out_src, $rose(out_valid_o) |-> $past(v3_q), "result without a summed item")

endmodule

// ----- rtl/hcm_hue2rgb.sv -----
// Full-saturation, full-value HSV to RGB conversion of one hue.
// Depends on hcm_pkg.
module hcm_hue2rgb (
  input  logic [hcm_pkg::HUE_BITS-1:0] hue_i,
  output hcm_pkg::rgb_t                rgb_o
);
  import hcm_pkg::*;

  typedef enum logic [2:0] {
    SEC_RED_GUP   = 3'd0,
    SEC_GRN_RDN   = 3'd1,
    SEC_GRN_BUP   = 3'd2,
    SEC_BLU_GDN   = 3'd3,
    SEC_BLU_RUP   = 3'd4,
    SEC_RED_BDN   = 3'd5
  } sector_e;

  logic [HUE_BITS+2:0]   h6;
  logic [HUE_BITS-1:0]   frac;
  logic [HFC_W-1:0]      fprod;
  logic [COLOR_BITS-1:0] fc;
  logic [COLOR_BITS-1:0] fi;
  sector_e               sector;

  assign h6     = ({3'b000, hue_i} << 1) + ({3'b000, hue_i} << 2);
  assign sector = sector_e'(h6[HUE_BITS+2:HUE_BITS]);
  assign frac   = h6[HUE_BITS-1:0];
  // frac * FULL, rounded back to a color value
  assign fprod  = {frac, {COLOR_BITS{1'b0}}} - {{COLOR_BITS{1'b0}}, frac} + HUE_HALF;
  assign fc     = fprod[HFC_W-1:HUE_BITS];
  assign fi     = FULL - fc;

  always_comb begin
    case (sector)
      SEC_RED_GUP: rgb_o = {{COLOR_BITS{1'b0}}, fc, FULL};
      SEC_GRN_RDN: rgb_o = {{COLOR_BITS{1'b0}}, FULL, fi};
      SEC_GRN_BUP: rgb_o = {fc, FULL, {COLOR_BITS{1'b0}}};
      SEC_BLU_GDN: rgb_o = {FULL, fi, {COLOR_BITS{1'b0}}};
      SEC_BLU_RUP: rgb_o = {FULL, {COLOR_BITS{1'b0}}, fc};
      default:     rgb_o = {fi, {COLOR_BITS{1'b0}}, FULL};
    endcase
  end

endmodule

// ----- rtl/hcm_lane.sv -----
// One output channel: three products, rounded sum, divide by full scale, clamp.
// Depends on hcm_pkg.
module hcm_lane (
  input  logic                          clk_i,
  input  hcm_pkg::stage_en_t            en_i,
  input  hcm_pkg::rgb_t                 x_i,
  input  hcm_pkg::rgb_t                 coef_i,
  output logic [hcm_pkg::COLOR_BITS-1:0] res_o
);
  import hcm_pkg::*;

  logic [2:0][PROD_W-1:0] prod_d, prod_q;
  logic [SUM_W-1:0]       sum_d, sum_q;
  logic [COLOR_BITS-1:0]  res_d, res_q;
  logic [COLOR_BITS-1:0]  q0;
  logic [COLOR_BITS:0]    rem;
  logic                   bump;
  logic                   sat;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_d[k] = PROD_W'(x_i[k]) * PROD_W'(coef_i[k]);
    end
  end

  assign sum_d = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]) + SUM_W'(HALF);

  // divide by 2^n - 1: quotient estimate from the high part, remainder is
  // low part plus estimate, which stays below twice full scale when not saturated
  assign sat  = (sum_q >= SAT_LIMIT);
  assign q0   = sum_q[2*COLOR_BITS-1:COLOR_BITS];
  assign rem  = {1'b0, sum_q[COLOR_BITS-1:0]} + {1'b0, q0};
  assign bump = (rem >= {1'b0, FULL});
  assign res_d = sat ? FULL : (q0 + {{(COLOR_BITS-1){1'b0}}, bump});

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      prod_q <= prod_d;
    end
    if (en_i.sum) begin
      sum_q <= sum_d;
    end
    if (en_i.res) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
